// File: rtl/core/mbgw_pkg.sv
package mbgw_pkg;

    // Default response buffer size in bytes
    localparam int BUF_BYTES_DEF = 256;

    // Input queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Command codes
    localparam logic [1:0] CMD_REQ   = 2'd0;
    localparam logic [1:0] CMD_SER   = 2'd1;
    localparam logic [1:0] CMD_DRAIN = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Result status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_LEN      = 3'd1;
    localparam logic [2:0] STS_STRAY    = 3'd2;
    localparam logic [2:0] STS_RSP_OVF  = 3'd3;
    localparam logic [2:0] STS_REQ_OVF  = 3'd4;
    localparam logic [2:0] STS_NO_DRAIN = 3'd5;

    // Output port select
    localparam logic PORT_SERIAL = 1'b0;
    localparam logic PORT_TCP    = 1'b1;

    // Gateway phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ARMED = 2'd1;
    localparam logic [1:0] PH_READY = 2'd2;

    // Modbus CRC-16 constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame layout
    localparam int HDR_BYTES = 6;
    localparam int CRC_BYTES = 2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       request_end;
    } t_in_item;

    typedef struct packed {
        logic       out_port;
        logic [7:0] out_byte;
        logic       out_last;
        logic [2:0] status;
    } t_out_item;

    // Fold one byte into the reflected CRC-16
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic t_out_item mk_res(input logic port, input logic [7:0] b,
                                         input logic last, input logic [2:0] sts);
        t_out_item r;
        r.out_port = port;
        r.out_byte = b;
        r.out_last = last;
        r.status   = sts;
        return r;
    endfunction

endpackage

// File: rtl/core/mbgw_front.sv
module mbgw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mbgw_pkg::t_in_item  i_in,
    output logic                o_hd_valid,
    output mbgw_pkg::t_in_item  o_hd,
    input  logic                i_pop
);

    mbgw_pkg::t_in_item         r_q [mbgw_pkg::Q_DEPTH];
    logic [mbgw_pkg::Q_AW-1:0]  r_wr_ptr;
    logic [mbgw_pkg::Q_AW-1:0]  r_rd_ptr;
    logic [mbgw_pkg::Q_AW:0]    r_cnt;
    logic                       push;
    logic                       pop;

    // Accept beats while the queue has room; unused selector beats are dropped here
    assign o_stall    = (r_cnt == (mbgw_pkg::Q_AW + 1)'(mbgw_pkg::Q_DEPTH));
    assign push       = i_valid && !o_stall && (i_in.cmd != mbgw_pkg::CMD_NONE);
    assign o_hd_valid = (r_cnt != '0);
    assign o_hd       = r_q[r_rd_ptr];
    assign pop        = i_pop && o_hd_valid;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= i_in;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/core/mbgw_back.sv
module mbgw_back #(
    parameter int BUF_BYTES = mbgw_pkg::BUF_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_hd_valid,
    input  mbgw_pkg::t_in_item  i_hd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output mbgw_pkg::t_out_item o_out
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int CW = AW + 1;

    localparam logic FSM_RUN  = 1'b0;
    localparam logic FSM_READ = 1'b1;

    // Gateway state
    logic [1:0]     r_phase,     n_phase;
    logic [CW-1:0]  r_req_cnt,   n_req_cnt;
    logic [31:0]    r_hdr,       n_hdr;
    logic [15:0]    r_decl,      n_decl;
    logic [15:0]    r_req_crc,   n_req_crc;
    logic [15:0]    r_rsp_crc,   n_rsp_crc;
    logic [CW-1:0]  r_rsp_cnt,   n_rsp_cnt;
    logic [CW-1:0]  r_drain_idx, n_drain_idx;

    // Drain read sequencing
    logic           r_fsm,       n_fsm;
    logic [CW-1:0]  r_d_sel,     n_d_sel;
    logic           r_d_last,    n_d_last;

    // Pending results and output register
    mbgw_pkg::t_out_item r_pend [3];
    mbgw_pkg::t_out_item n_pend [3];
    logic [1:0]          r_pend_cnt, n_pend_cnt;
    logic                r_o_valid;
    mbgw_pkg::t_out_item r_o_out;

    // Response buffer
    logic [7:0]     r_mem [BUF_BYTES];
    logic [7:0]     r_rd_data;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    logic           out_free;
    logic           can_load;

    assign out_free = !r_o_valid || !i_stall;
    assign can_load = (r_pend_cnt == 2'd0) || ((r_pend_cnt == 2'd1) && out_free);
    assign o_valid  = r_o_valid;
    assign o_out    = r_o_out;

    // Item execution
    always_comb begin
        mbgw_pkg::t_out_item res [3];
        logic [1:0]    res_n;
        logic [CW-1:0] cnt1;
        logic [15:0]   crc1;
        logic [15:0]   plen;
        logic [7:0]    v;
        logic          last;

        n_phase     = r_phase;
        n_req_cnt   = r_req_cnt;
        n_hdr       = r_hdr;
        n_decl      = r_decl;
        n_req_crc   = r_req_crc;
        n_rsp_crc   = r_rsp_crc;
        n_rsp_cnt   = r_rsp_cnt;
        n_drain_idx = r_drain_idx;
        n_fsm       = r_fsm;
        n_d_sel     = r_d_sel;
        n_d_last    = r_d_last;
        mem_we      = 1'b0;
        mem_wa      = r_rsp_cnt[AW-1:0];
        rd_en       = 1'b0;
        rd_addr     = AW'(r_drain_idx - CW'(mbgw_pkg::HDR_BYTES));
        res[0]      = '0;
        res[1]      = '0;
        res[2]      = '0;
        res_n       = 2'd0;
        cnt1        = '0;
        crc1        = '0;
        plen        = 16'(r_rsp_cnt) - 16'(mbgw_pkg::CRC_BYTES);
        v           = '0;
        last        = 1'b0;

        o_pop = (r_fsm == FSM_RUN) && i_hd_valid && can_load;

        if (o_pop) begin
            case (i_hd.cmd)
                mbgw_pkg::CMD_REQ: begin
                    if (r_req_cnt >= CW'(BUF_BYTES - 2)) begin
                        // Request too long: drop the byte
                        res[0] = mbgw_pkg::mk_res(mbgw_pkg::PORT_SERIAL, 8'h00, 1'b0,
                                                  mbgw_pkg::STS_REQ_OVF);
                        res_n  = 2'd1;
                        if (i_hd.request_end) begin
                            n_req_cnt = '0;
                            n_req_crc = mbgw_pkg::CRC_INIT;
                        end
                    end else begin
                        cnt1      = r_req_cnt + 1'b1;
                        n_req_cnt = cnt1;
                        if (r_req_cnt < CW'(4)) begin
                            n_hdr = {r_hdr[23:0], i_hd.data_byte};
                        end else if (r_req_cnt < CW'(mbgw_pkg::HDR_BYTES)) begin
                            n_decl = {r_decl[7:0], i_hd.data_byte};
                        end else begin
                            n_req_crc = mbgw_pkg::crc_fold(r_req_crc, i_hd.data_byte);
                            res[0]    = mbgw_pkg::mk_res(mbgw_pkg::PORT_SERIAL,
                                                         i_hd.data_byte, 1'b0,
                                                         mbgw_pkg::STS_OK);
                            res_n     = 2'd1;
                        end
                        if (i_hd.request_end) begin
                            if ((cnt1 < CW'(mbgw_pkg::HDR_BYTES)) ||
                                (16'(cnt1 - CW'(mbgw_pkg::HDR_BYTES)) != n_decl)) begin
                                res[res_n] = mbgw_pkg::mk_res(mbgw_pkg::PORT_SERIAL, 8'h00,
                                                              1'b0, mbgw_pkg::STS_LEN);
                                res_n      = res_n + 2'd1;
                            end else begin
                                // Append CRC low byte first, then arm the response
                                res[res_n] = mbgw_pkg::mk_res(mbgw_pkg::PORT_SERIAL,
                                                              n_req_crc[7:0], 1'b0,
                                                              mbgw_pkg::STS_OK);
                                res[res_n + 2'd1] = mbgw_pkg::mk_res(mbgw_pkg::PORT_SERIAL,
                                                                     n_req_crc[15:8], 1'b1,
                                                                     mbgw_pkg::STS_OK);
                                res_n       = res_n + 2'd2;
                                n_phase     = mbgw_pkg::PH_ARMED;
                                n_rsp_cnt   = '0;
                                n_rsp_crc   = mbgw_pkg::CRC_INIT;
                                n_drain_idx = '0;
                            end
                            n_req_cnt = '0;
                            n_req_crc = mbgw_pkg::CRC_INIT;
                        end
                    end
                end
                mbgw_pkg::CMD_SER: begin
                    if (r_phase != mbgw_pkg::PH_ARMED) begin
                        res[0] = mbgw_pkg::mk_res(mbgw_pkg::PORT_SERIAL, 8'h00, 1'b0,
                                                  mbgw_pkg::STS_STRAY);
                        res_n  = 2'd1;
                    end else begin
                        mem_we    = 1'b1;
                        cnt1      = r_rsp_cnt + 1'b1;
                        crc1      = mbgw_pkg::crc_fold(r_rsp_crc, i_hd.data_byte);
                        n_rsp_cnt = cnt1;
                        n_rsp_crc = crc1;
                        if ((cnt1 >= CW'(mbgw_pkg::HDR_BYTES)) && (crc1 == 16'h0000)) begin
                            n_phase     = mbgw_pkg::PH_READY;
                            n_drain_idx = '0;
                        end else if ((cnt1 + CW'(mbgw_pkg::HDR_BYTES)) >= CW'(BUF_BYTES)) begin
                            n_phase   = mbgw_pkg::PH_IDLE;
                            n_rsp_cnt = '0;
                            n_rsp_crc = mbgw_pkg::CRC_INIT;
                            res[0]    = mbgw_pkg::mk_res(mbgw_pkg::PORT_SERIAL, 8'h00, 1'b0,
                                                         mbgw_pkg::STS_RSP_OVF);
                            res_n     = 2'd1;
                        end
                    end
                end
                mbgw_pkg::CMD_DRAIN: begin
                    if (r_phase != mbgw_pkg::PH_READY) begin
                        res[0] = mbgw_pkg::mk_res(mbgw_pkg::PORT_SERIAL, 8'h00, 1'b0,
                                                  mbgw_pkg::STS_NO_DRAIN);
                        res_n  = 2'd1;
                    end else begin
                        // Start buffer read; result is built in the read state
                        last     = ((r_drain_idx + 1'b1) >=
                                    (r_rsp_cnt + CW'(mbgw_pkg::HDR_BYTES - mbgw_pkg::CRC_BYTES)));
                        rd_en    = 1'b1;
                        n_d_sel  = r_drain_idx;
                        n_d_last = last;
                        n_fsm    = FSM_READ;
                        if (last) begin
                            n_phase     = mbgw_pkg::PH_IDLE;
                            n_drain_idx = '0;
                        end else begin
                            n_drain_idx = r_drain_idx + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if ((r_fsm == FSM_READ) && can_load) begin
            // Rebuilt TCP header, then stored RTU bytes
            if (r_d_sel < CW'(4)) begin
                case (r_d_sel[1:0])
                    2'd0:    v = r_hdr[31:24];
                    2'd1:    v = r_hdr[23:16];
                    2'd2:    v = r_hdr[15:8];
                    default: v = r_hdr[7:0];
                endcase
            end else if (r_d_sel == CW'(4)) begin
                v = plen[15:8];
            end else if (r_d_sel == CW'(5)) begin
                v = plen[7:0];
            end else begin
                v = r_rd_data;
            end
            res[0] = mbgw_pkg::mk_res(mbgw_pkg::PORT_TCP, v, r_d_last, mbgw_pkg::STS_OK);
            res_n  = 2'd1;
            n_fsm  = FSM_RUN;
        end

        // Pending queue: shift out one, then load new results
        n_pend[0]  = r_pend[0];
        n_pend[1]  = r_pend[1];
        n_pend[2]  = r_pend[2];
        n_pend_cnt = r_pend_cnt;
        if (out_free && (r_pend_cnt != 2'd0)) begin
            n_pend[0]  = r_pend[1];
            n_pend[1]  = r_pend[2];
            n_pend_cnt = r_pend_cnt - 2'd1;
        end
        if (res_n != 2'd0) begin
            n_pend[0]  = res[0];
            n_pend[1]  = res[1];
            n_pend[2]  = res[2];
            n_pend_cnt = res_n;
        end
    end

    // Response buffer, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= i_hd.data_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend[0] <= n_pend[0];
        r_pend[1] <= n_pend[1];
        r_pend[2] <= n_pend[2];
        r_d_sel   <= n_d_sel;
        r_d_last  <= n_d_last;
        if (out_free && (r_pend_cnt != 2'd0)) begin
            r_o_out <= r_pend[0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mbgw_pkg::PH_IDLE;
            r_req_cnt   <= '0;
            r_hdr       <= '0;
            r_decl      <= '0;
            r_req_crc   <= mbgw_pkg::CRC_INIT;
            r_rsp_crc   <= mbgw_pkg::CRC_INIT;
            r_rsp_cnt   <= '0;
            r_drain_idx <= '0;
            r_fsm       <= FSM_RUN;
            r_pend_cnt  <= 2'd0;
            r_o_valid   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_req_cnt   <= n_req_cnt;
            r_hdr       <= n_hdr;
            r_decl      <= n_decl;
            r_req_crc   <= n_req_crc;
            r_rsp_crc   <= n_rsp_crc;
            r_rsp_cnt   <= n_rsp_cnt;
            r_drain_idx <= n_drain_idx;
            r_fsm       <= n_fsm;
            r_pend_cnt  <= n_pend_cnt;
            if (out_free) begin
                r_o_valid <= (r_pend_cnt != 2'd0);
            end
        end
    end

endmodule

// File: rtl/core/modbus_tcp_rtu_gateway.sv
// Modbus TCP to RTU gateway.
// Input channel (i_valid/o_stall, i_in): one beat per command: a TCP request
// byte, a serial response byte, or a drain request for one TCP response byte.
// Output channel (o_valid/i_stall, o_out): RTU bytes with appended CRC-16,
// rebuilt TCP response bytes, and error status beats.
// Beats enter a 4-entry queue; the back end executes one beat per cycle
// while its output can take the results, except that a drain beat holds off
// the next beat until its registered response buffer read completes. Each
// beat yields zero to three result beats, sent one per cycle unless the
// receiver stalls.
// Reset (synchronous, active low) returns to idle with no response pending
// and clears counters and CRCs; buffer contents are not cleared.
// When the receiver stalls, the output beat holds, up to three results wait
// in the back end, input beats fill the queue and then o_stall rises.
module modbus_tcp_rtu_gateway #(
    parameter int BUF_BYTES = mbgw_pkg::BUF_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mbgw_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output mbgw_pkg::t_out_item o_out
);

    logic               hd_valid;
    mbgw_pkg::t_in_item hd;
    logic               pop;

    mbgw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_hd_valid (hd_valid),
        .o_hd       (hd),
        .i_pop      (pop)
    );

    mbgw_back #(
        .BUF_BYTES (BUF_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hd_valid (hd_valid),
        .i_hd       (hd),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out)
    );

endmodule

// File: bench/modbus_tcp_rtu_gateway_test.sv
module modbus_tcp_rtu_gateway_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF           = mbgw_pkg::BUF_BYTES_DEF;
    localparam int MIN_RTU_FRAME = 6;
    localparam int TOTAL_BEATS   = 430;
    localparam int CALM_BEATS    = 60;
    localparam int MAX_SHOWN     = 10;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    mbgw_pkg::t_in_item  i_in    = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    mbgw_pkg::t_out_item o_out;

    // Gateway mirror: tracks request/response state, queues the beats it must emit
    class gateway_mirror;
        logic [1:0]          phase;
        logic [8:0]          req_cnt;
        logic [31:0]         ids;
        logic [15:0]         decl_len;
        logic [15:0]         req_crc;
        logic [15:0]         rsp_crc;
        logic [8:0]          rsp_cnt;
        logic [7:0]          rsp_mem [BUF];
        logic [8:0]          drain_pos;
        mbgw_pkg::t_out_item awaited[$];
        int                  errors;

        function new();
            phase     = mbgw_pkg::PH_IDLE;
            req_cnt   = '0;
            ids       = '0;
            decl_len  = '0;
            req_crc   = mbgw_pkg::CRC_INIT;
            rsp_crc   = mbgw_pkg::CRC_INIT;
            rsp_cnt   = '0;
            drain_pos = '0;
            errors    = 0;
        endfunction

        // Reflected Modbus CRC-16, one byte at a time
        function logic [15:0] crc_add(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ mbgw_pkg::CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function void push(logic port, logic [7:0] b, logic last, logic [2:0] sts);
            mbgw_pkg::t_out_item r;
            r.out_port = port;
            r.out_byte = b;
            r.out_last = last;
            r.status   = sts;
            awaited.push_back(r);
        endfunction

        // Accepted input beat: advance state, queue the beats it causes
        function void take_beat(mbgw_pkg::t_in_item it);
            logic [8:0] pos;
            logic [8:0] plen;
            logic [8:0] d;
            logic [7:0] v;
            case (it.cmd)
                mbgw_pkg::CMD_REQ: begin
                    if (req_cnt >= 9'(BUF - mbgw_pkg::CRC_BYTES)) begin
                        // no room left for the byte plus the CRC
                        push(mbgw_pkg::PORT_SERIAL, 8'h00, 1'b0, mbgw_pkg::STS_REQ_OVF);
                        if (it.request_end) begin
                            req_cnt = '0;
                            req_crc = mbgw_pkg::CRC_INIT;
                        end
                    end else begin
                        pos     = req_cnt;
                        req_cnt = req_cnt + 1'b1;
                        if (pos < 4) begin
                            ids = {ids[23:0], it.data_byte};
                        end else if (pos < 9'(mbgw_pkg::HDR_BYTES)) begin
                            decl_len = {decl_len[7:0], it.data_byte};
                        end else begin
                            req_crc = crc_add(req_crc, it.data_byte);
                            push(mbgw_pkg::PORT_SERIAL, it.data_byte, 1'b0,
                                 mbgw_pkg::STS_OK);
                        end
                        if (it.request_end) begin
                            if (req_cnt < 9'(mbgw_pkg::HDR_BYTES) ||
                                16'(req_cnt - 9'(mbgw_pkg::HDR_BYTES)) != decl_len) begin
                                push(mbgw_pkg::PORT_SERIAL, 8'h00, 1'b0, mbgw_pkg::STS_LEN);
                            end else begin
                                push(mbgw_pkg::PORT_SERIAL, req_crc[7:0], 1'b0,
                                     mbgw_pkg::STS_OK);
                                push(mbgw_pkg::PORT_SERIAL, req_crc[15:8], 1'b1,
                                     mbgw_pkg::STS_OK);
                                phase     = mbgw_pkg::PH_ARMED;
                                rsp_cnt   = '0;
                                rsp_crc   = mbgw_pkg::CRC_INIT;
                                drain_pos = '0;
                            end
                            req_cnt = '0;
                            req_crc = mbgw_pkg::CRC_INIT;
                        end
                    end
                end
                mbgw_pkg::CMD_SER: begin
                    if (phase != mbgw_pkg::PH_ARMED) begin
                        push(mbgw_pkg::PORT_SERIAL, 8'h00, 1'b0, mbgw_pkg::STS_STRAY);
                    end else begin
                        rsp_mem[rsp_cnt] = it.data_byte;
                        rsp_cnt = rsp_cnt + 1'b1;
                        rsp_crc = crc_add(rsp_crc, it.data_byte);
                        // zero residue closes the frame; otherwise watch for overflow
                        if (rsp_cnt >= 9'(MIN_RTU_FRAME) && rsp_crc == 16'h0000) begin
                            phase     = mbgw_pkg::PH_READY;
                            drain_pos = '0;
                        end else if (int'(rsp_cnt) + mbgw_pkg::HDR_BYTES >= BUF) begin
                            phase   = mbgw_pkg::PH_IDLE;
                            rsp_cnt = '0;
                            rsp_crc = mbgw_pkg::CRC_INIT;
                            push(mbgw_pkg::PORT_SERIAL, 8'h00, 1'b0, mbgw_pkg::STS_RSP_OVF);
                        end
                    end
                end
                mbgw_pkg::CMD_DRAIN: begin
                    if (phase != mbgw_pkg::PH_READY) begin
                        push(mbgw_pkg::PORT_SERIAL, 8'h00, 1'b0, mbgw_pkg::STS_NO_DRAIN);
                    end else begin
                        plen = rsp_cnt - 9'(mbgw_pkg::CRC_BYTES);
                        d    = drain_pos;
                        case (d)
                            9'd0:    v = ids[31:24];
                            9'd1:    v = ids[23:16];
                            9'd2:    v = ids[15:8];
                            9'd3:    v = ids[7:0];
                            9'd4:    v = {7'd0, plen[8]};
                            9'd5:    v = plen[7:0];
                            default: v = rsp_mem[d - 9'(mbgw_pkg::HDR_BYTES)];
                        endcase
                        if (d + 1'b1 >= plen + 9'(mbgw_pkg::HDR_BYTES)) begin
                            push(mbgw_pkg::PORT_TCP, v, 1'b1, mbgw_pkg::STS_OK);
                            phase     = mbgw_pkg::PH_IDLE;
                            drain_pos = '0;
                        end else begin
                            push(mbgw_pkg::PORT_TCP, v, 1'b0, mbgw_pkg::STS_OK);
                            drain_pos = d + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Accepted output beat against the oldest queued one
        function void check_beat(mbgw_pkg::t_out_item got);
            mbgw_pkg::t_out_item want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("%0t: unexpected beat port %0d byte %02h last %0d status %0d",
                             $time, got.out_port, got.out_byte, got.out_last, got.status);
                end
                return;
            end
            want = awaited.pop_front();
            if (got.out_port !== want.out_port || got.out_byte !== want.out_byte ||
                got.out_last !== want.out_last || got.status !== want.status) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("%0t: expected port %0d byte %02h last %0d status %0d", $time,
                             want.out_port, want.out_byte, want.out_last, want.status);
                    $display("%0t:      got port %0d byte %02h last %0d status %0d", $time,
                             got.out_port, got.out_byte, got.out_last, got.status);
                end
            end
        endfunction
    endclass

    gateway_mirror sb = new();
    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;
    int beats_sent = 0;

    modbus_tcp_rtu_gateway #(
        .BUF_BYTES(BUF)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_in   (i_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out  (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output side: check accepted beats, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_beat(o_out);
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // One input beat, with an optional gap in front of it
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b, input logic fin);
        mbgw_pkg::t_in_item beat;
        int                 n;
        beat.cmd         = cmd;
        beat.data_byte   = b;
        beat.request_end = fin;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            n = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in    <= beat;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_beat(beat);
        beats_sent++;
    endtask

    // TCP request: ids, declared length, random payload; end flag on the last byte
    task automatic send_request(input logic [31:0] ids, input int n_pay,
                                input logic [15:0] decl);
        for (int k = 0; k < 4; k++) begin
            send_beat(mbgw_pkg::CMD_REQ, ids[31 - 8 * k -: 8], 1'b0);
        end
        send_beat(mbgw_pkg::CMD_REQ, decl[15:8], 1'b0);
        send_beat(mbgw_pkg::CMD_REQ, decl[7:0], n_pay == 0);
        for (int k = 0; k < n_pay; k++) begin
            send_beat(mbgw_pkg::CMD_REQ, 8'($urandom), k == n_pay - 1);
        end
    endtask

    // RTU response: random payload and its CRC, optionally corrupted
    task automatic send_response(input int n_pay, input bit intact);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = mbgw_pkg::CRC_INIT;
        for (int k = 0; k < n_pay; k++) begin
            b   = 8'($urandom);
            crc = sb.crc_add(crc, b);
            send_beat(mbgw_pkg::CMD_SER, b, 1'($urandom));
        end
        if (!intact) begin
            crc = crc ^ 16'(1 << $urandom_range(0, 15));
        end
        send_beat(mbgw_pkg::CMD_SER, crc[7:0], 1'($urandom));
        send_beat(mbgw_pkg::CMD_SER, crc[15:8], 1'($urandom));
    endtask

    task automatic send_drains(input int n);
        for (int k = 0; k < n; k++) begin
            send_beat(mbgw_pkg::CMD_DRAIN, 8'($urandom), 1'($urandom));
        end
    endtask

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 30;
        endcase
    endfunction

    initial begin
        int          pick;
        int          n_pay;
        int          n_rsp;
        int          n_drain;
        int          n;
        bit          intact;
        logic [15:0] decl;
        logic [1:0]  cmd;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: error paths, extremes, empty payload
        gap_pct   = 20;
        stall_pct = 20;
        send_beat(mbgw_pkg::CMD_DRAIN, 8'h00, 1'b0);        // nothing ready
        send_beat(mbgw_pkg::CMD_SER, 8'hFF, 1'b1);          // serial byte while idle
        send_beat(mbgw_pkg::CMD_NONE, 8'hFF, 1'b1);         // unused selector, no beat out
        send_beat(mbgw_pkg::CMD_REQ, 8'h00, 1'b0);
        send_beat(mbgw_pkg::CMD_REQ, 8'hFF, 1'b1);          // request shorter than header
        send_request(32'hFFFF_0000, 1, 16'hFFFF);           // declared length disagrees
        send_request(32'h0000_FFFF, 0, 16'h0000);           // empty payload arms
        send_beat(mbgw_pkg::CMD_DRAIN, 8'hFF, 1'b1);        // armed, not ready yet

        // Response that never closes, then a serial byte after the reset to idle
        send_request(32'($urandom), 2, 16'd2);
        for (int k = 0; k < BUF - mbgw_pkg::HDR_BYTES; k++) begin
            send_beat(mbgw_pkg::CMD_SER, 8'($urandom), 1'($urandom));
        end
        send_beat(mbgw_pkg::CMD_SER, 8'($urandom), 1'b0);

        // Random: mostly whole transactions, some broken requests and noise
        while (beats_sent < TOTAL_BEATS) begin
            if (beats_sent >= TOTAL_BEATS - CALM_BEATS) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if ($urandom_range(0, 6) == 0) begin
                gap_pct   = pick_rate();
                stall_pct = pick_rate();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                n_pay = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
                send_request(32'($urandom), n_pay, 16'(n_pay));
                if ($urandom_range(0, 9) != 0) begin
                    n_rsp  = $urandom_range(MIN_RTU_FRAME - mbgw_pkg::CRC_BYTES, 12);
                    intact = ($urandom_range(0, 6) != 0);
                    send_response(n_rsp, intact);
                    if (!intact) begin
                        n_drain = $urandom_range(1, 2);
                    end else if ($urandom_range(0, 9) == 0) begin
                        // cut short; next request discards the rest
                        n_drain = $urandom_range(1, n_rsp + mbgw_pkg::HDR_BYTES - 1);
                    end else begin
                        n_drain = n_rsp + mbgw_pkg::HDR_BYTES +
                                  int'($urandom_range(0, 4) == 0);
                    end
                    send_drains(n_drain);
                end
            end else if (pick < 70) begin
                if ($urandom_range(0, 2) == 0) begin
                    n_pay = $urandom_range(1, mbgw_pkg::HDR_BYTES - 1);
                    for (int k = 0; k < n_pay; k++) begin
                        send_beat(mbgw_pkg::CMD_REQ, 8'($urandom), k == n_pay - 1);
                    end
                end else begin
                    n_pay = $urandom_range(0, 8);
                    decl  = $urandom_range(0, 1) ? 16'(n_pay + 1) : 16'($urandom);
                    if (decl == 16'(n_pay)) begin
                        decl = decl + 1'b1;
                    end
                    send_request(32'($urandom), n_pay, decl);
                end
            end else begin
                // noise; request bytes always end so later requests stay aligned
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    cmd = 2'($urandom);
                    send_beat(cmd, 8'($urandom),
                              (cmd == mbgw_pkg::CMD_REQ) ? 1'b1 : 1'($urandom));
                end
            end
        end

        // Drain out, then wait with the input idle to catch stray beats
        i_valid  <= 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
